// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the segment intersection unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define SIP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked at every edge, also while reset is held.
`define SIP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define SIP_ASSERT(label, prop)
`define SIP_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: src/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Types shared by the stages of the segment intersection unit.
// ----------------------------------------------------------------------------
package sip_pkg;

    // Control that travels beside the numerator and denominator words.
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } sip_ctl_t;

    localparam int unsigned NUM_COORDS = 8;

endpackage

// File: src/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front
// Five register stages: line equations, side tests, determinant and the
// numerators, ending in unsigned dividend and divisor words for the divider.
// ----------------------------------------------------------------------------
module sip_front #(
    parameter int unsigned W   = 16,
    parameter int unsigned IW  = 128,
    parameter int unsigned NW  = 52,
    parameter int unsigned SW  = 35
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [IW-1:0]        in_data,
    output sip_pkg::sip_ctl_t    ctl,
    output logic [NW-1:0]        num_x,
    output logic [NW-1:0]        num_y,
    output logic [SW-1:0]        den
);

    localparam int unsigned CW = W + 1;
    localparam int unsigned PW = 2 * W + 1;

    // Stage 1
    logic                 v1_reg;
    logic signed [W-1:0]  crd_reg [sip_pkg::NUM_COORDS];
    logic signed [CW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [PW-1:0] pc_reg [4];
    // Stage 2
    logic                 v2_reg;
    logic signed [CW-1:0] a1_2_reg, b1_2_reg, a2_2_reg, b2_2_reg;
    logic signed [PW-1:0] c1_reg, c2_reg;
    logic signed [SW-1:0] ps_reg [8];
    logic signed [SW-1:0] pd_reg [2];
    // Stage 3
    logic                 v3_reg;
    logic signed [SW-1:0] side_reg [4];
    logic signed [SW-1:0] det3_reg;
    logic signed [NW-1:0] pn_reg [4];
    // Stage 4
    logic                 v4_reg;
    logic                 hit4_reg;
    logic signed [SW-1:0] det4_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;
    // Stage 5
    logic                 v5_reg;
    logic                 hit5_reg;
    logic                 negx5_reg, negy5_reg;
    logic [NW-1:0]        numx_reg, numy_reg;
    logic [SW-1:0]        den_reg;

    logic [NW-1:0]        magx, magy;
    logic [SW-1:0]        magd;
    logic                 same_a, same_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Coordinates: 0 ax1, 1 ay1, 2 ax2, 3 ay2, 4 bx1, 5 by1, 6 bx2, 7 by2.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < sip_pkg::NUM_COORDS; i++)
            begin
                crd_reg[i] <= in_data[i*W +: W];
            end
            a1_reg    <= CW'($signed(in_data[3*W +: W])) - CW'($signed(in_data[1*W +: W]));
            b1_reg    <= CW'($signed(in_data[0*W +: W])) - CW'($signed(in_data[2*W +: W]));
            a2_reg    <= CW'($signed(in_data[7*W +: W])) - CW'($signed(in_data[5*W +: W]));
            b2_reg    <= CW'($signed(in_data[4*W +: W])) - CW'($signed(in_data[6*W +: W]));
            pc_reg[0] <= PW'($signed(in_data[2*W +: W])) * PW'($signed(in_data[1*W +: W]));
            pc_reg[1] <= PW'($signed(in_data[0*W +: W])) * PW'($signed(in_data[3*W +: W]));
            pc_reg[2] <= PW'($signed(in_data[6*W +: W])) * PW'($signed(in_data[5*W +: W]));
            pc_reg[3] <= PW'($signed(in_data[4*W +: W])) * PW'($signed(in_data[7*W +: W]));

            a1_2_reg  <= a1_reg;
            b1_2_reg  <= b1_reg;
            a2_2_reg  <= a2_reg;
            b2_2_reg  <= b2_reg;
            c1_reg    <= pc_reg[0] - pc_reg[1];
            c2_reg    <= pc_reg[2] - pc_reg[3];
            // B endpoints against line A, then A endpoints against line B.
            ps_reg[0] <= SW'(a1_reg) * SW'(crd_reg[4]);
            ps_reg[1] <= SW'(b1_reg) * SW'(crd_reg[5]);
            ps_reg[2] <= SW'(a1_reg) * SW'(crd_reg[6]);
            ps_reg[3] <= SW'(b1_reg) * SW'(crd_reg[7]);
            ps_reg[4] <= SW'(a2_reg) * SW'(crd_reg[0]);
            ps_reg[5] <= SW'(b2_reg) * SW'(crd_reg[1]);
            ps_reg[6] <= SW'(a2_reg) * SW'(crd_reg[2]);
            ps_reg[7] <= SW'(b2_reg) * SW'(crd_reg[3]);
            pd_reg[0] <= SW'(a1_reg) * SW'(b2_reg);
            pd_reg[1] <= SW'(a2_reg) * SW'(b1_reg);

            side_reg[0] <= ps_reg[0] + ps_reg[1] + SW'(c1_reg);
            side_reg[1] <= ps_reg[2] + ps_reg[3] + SW'(c1_reg);
            side_reg[2] <= ps_reg[4] + ps_reg[5] + SW'(c2_reg);
            side_reg[3] <= ps_reg[6] + ps_reg[7] + SW'(c2_reg);
            det3_reg    <= pd_reg[0] - pd_reg[1];
            pn_reg[0]   <= NW'(b1_2_reg) * NW'(c2_reg);
            pn_reg[1]   <= NW'(b2_2_reg) * NW'(c1_reg);
            pn_reg[2]   <= NW'(a2_2_reg) * NW'(c1_reg);
            pn_reg[3]   <= NW'(a1_2_reg) * NW'(c2_reg);

            hit4_reg <= !(same_a || same_b || (det3_reg == '0));
            det4_reg <= det3_reg;
            nx_reg   <= pn_reg[0] - pn_reg[1];
            ny_reg   <= pn_reg[2] - pn_reg[3];

            hit5_reg  <= hit4_reg;
            negx5_reg <= nx_reg[NW-1] ^ det4_reg[SW-1];
            negy5_reg <= ny_reg[NW-1] ^ det4_reg[SW-1];
            // Rounding offset: divide 2|n| + |d| by 2|d|.
            numx_reg <= {magx[NW-2:0], 1'b0} + NW'(magd);
            numy_reg <= {magy[NW-2:0], 1'b0} + NW'(magd);
            den_reg  <= {magd[SW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        same_a = (side_reg[0] != '0) && (side_reg[1] != '0)
                 && (side_reg[0][SW-1] == side_reg[1][SW-1]);
        same_b = (side_reg[2] != '0) && (side_reg[3] != '0)
                 && (side_reg[2][SW-1] == side_reg[3][SW-1]);
        magx   = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        magy   = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
        magd   = det4_reg[SW-1] ? SW'(-det4_reg) : SW'(det4_reg);
    end

    assign ctl   = '{valid: v5_reg, hit: hit5_reg, neg_x: negx5_reg, neg_y: negy5_reg};
    assign num_x = numx_reg;
    assign num_y = numy_reg;
    assign den   = den_reg;

endmodule

// File: src/sip_div.sv
// ----------------------------------------------------------------------------
// sip_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sip_div #(
    parameter int unsigned NW  = 52,
    parameter int unsigned DVW = 35,
    parameter int unsigned Q   = 17
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic           in_neg,
    input  logic           in_tag,
    input  logic [NW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           out_valid,
    output logic           out_neg,
    output logic           out_tag,
    output logic [Q-1:0]   quotient
);

    localparam int unsigned RW = DVW + 1;

    logic           v_reg   [Q];
    logic           neg_reg [Q];
    logic           tag_reg [Q];
    logic [RW-1:0]  rem_reg [Q];
    logic [Q-1:0]   low_reg [Q];
    logic [Q-1:0]   quo_reg [Q];
    logic [DVW-1:0] dvs_reg [Q];

    for (genvar s = 0; s < Q; s++)
    begin : g_stage
        logic [RW-1:0]  rem_in, trial, rem_next;
        logic [Q-1:0]   low_in, quo_in;
        logic [DVW-1:0] dvs_in;
        logic           v_in, neg_in, tag_in, qbit;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                // Upper dividend bits seed the partial remainder.
                rem_in = RW'(dividend[NW-1:Q]);
                low_in = dividend[Q-1:0];
                quo_in = '0;
                dvs_in = divisor;
                v_in   = in_valid;
                neg_in = in_neg;
                tag_in = in_tag;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                rem_in = rem_reg[s-1];
                low_in = low_reg[s-1];
                quo_in = quo_reg[s-1];
                dvs_in = dvs_reg[s-1];
                v_in   = v_reg[s-1];
                neg_in = neg_reg[s-1];
                tag_in = tag_reg[s-1];
            end
        end

        always_comb
        begin
            trial    = {rem_in[RW-2:0], low_in[Q-1]};
            qbit     = (trial >= RW'(dvs_in));
            rem_next = qbit ? (trial - RW'(dvs_in)) : trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                low_reg[s] <= {low_in[Q-2:0], 1'b0};
                quo_reg[s] <= {quo_in[Q-2:0], qbit};
                dvs_reg[s] <= dvs_in;
                neg_reg[s] <= neg_in;
                tag_reg[s] <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[Q-1];
    assign out_neg   = neg_reg[Q-1];
    assign out_tag   = tag_reg[Q-1];
    assign quotient  = quo_reg[Q-1];

endmodule

// File: src/segment_intersection_point_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_unit
// Finds the rounded crossing point of two line segments.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat carries both segments, eight signed coordinates.
// Output channel m_*: one beat per input beat, in order. m_tuser is the hit
// flag; m_tdata holds cross_x and cross_y, both zero when there is no hit.
// From the accepting edge to m_tvalid the beat crosses five stages of line,
// side and determinant arithmetic, one stage per quotient bit in the two
// parallel dividers (COORD_WIDTH + 1), and the output register, the first
// of these loading at the accepting edge. A new beat is taken every cycle
// while s_tready is high, so throughput is one beat per cycle.
// All stages move together on one enable. When m_tready is low with a beat
// waiting at the output, s_tready drops and the whole pipeline holds, so
// nothing is lost or repeated; while the output register is empty the
// pipeline keeps advancing.
// Reset clears all valid bits; no output appears until beats are accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_point_unit #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // cross_x, cross_y, zero fill
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    // hit
    output logic                                   m_tuser
);

    localparam int unsigned W   = COORD_WIDTH;
    localparam int unsigned IW  = ((8*W+7)/8)*8;
    localparam int unsigned OW  = ((2*W+7)/8)*8;
    localparam int unsigned SW  = 2 * W + 3;
    localparam int unsigned NW  = 3 * W + 4;
    localparam int unsigned Q   = W + 1;

    logic              en;
    sip_pkg::sip_ctl_t ctl;
    logic [NW-1:0]     num_x, num_y;
    logic [SW-1:0]     den;
    logic              vx, vy, negx, negy, hitx, hity;
    logic [Q-1:0]      qx, qy;
    logic [Q-1:0]      sx, sy;

    logic              out_valid_reg;
    logic              hit_reg;
    logic [W-1:0]      cx_reg, cy_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    sip_front #(.W(W), .IW(IW), .NW(NW), .SW(SW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .ctl      (ctl),
        .num_x    (num_x),
        .num_y    (num_y),
        .den      (den)
    );

    sip_div #(.NW(NW), .DVW(SW), .Q(Q)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ctl.valid),
        .in_neg    (ctl.neg_x),
        .in_tag    (ctl.hit),
        .dividend  (num_x),
        .divisor   (den),
        .out_valid (vx),
        .out_neg   (negx),
        .out_tag   (hitx),
        .quotient  (qx)
    );

    sip_div #(.NW(NW), .DVW(SW), .Q(Q)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ctl.valid),
        .in_neg    (ctl.neg_y),
        .in_tag    (ctl.hit),
        .dividend  (num_y),
        .divisor   (den),
        .out_valid (vy),
        .out_neg   (negy),
        .out_tag   (hity),
        .quotient  (qy)
    );

    always_comb
    begin
        sx = negx ? (~qx + Q'(1)) : qx;
        sy = negy ? (~qy + Q'(1)) : qy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hitx;
            cx_reg  <= hitx ? sx[W-1:0] : '0;
            cy_reg  <= hitx ? sy[W-1:0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = OW'({cy_reg, cx_reg});

    `SIP_ASSERT(a_lanes_aligned, (vx == vy) && (!vx || (hitx == hity)))
    `SIP_ASSERT(a_miss_is_zero, (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    `SIP_ASSERT(a_drain_to_output, (s_tready && vx) |=> m_tvalid)
    `SIP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_tvalid)

endmodule
